/* design/cell_handoff_decision_core_defines.svh */
`ifndef CELL_HANDOFF_DECISION_CORE_DEFINES_SVH
`define CELL_HANDOFF_DECISION_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define CHD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define CHD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/chd_pkg.sv */
`timescale 1ns / 1ps

package chd_pkg;

  localparam int COORD_BITS      = 10;
  localparam int POWER_FRAC_BITS = 4;

  localparam int NUM_STATIONS = 4;
  localparam int STN_W        = 2;
  localparam int SERV_W       = 3;
  localparam int POS_W        = 10;
  localparam int XY_W         = 20;
  localparam int PWR_W        = 12;
  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 16;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam int D2_W          = 2 * COORD_BITS + 1;
  localparam int EXP_W         = $clog2(D2_W);
  localparam int LOG_FRAC_BITS = 16;
  localparam int MANT_W        = 31;
  localparam int LOG_W         = EXP_W + LOG_FRAC_BITS;
  localparam int TENLOG2_W     = 18;
  localparam int TLOG_W        = LOG_W + TENLOG2_W;
  localparam int RND_SHIFT     = 32 - POWER_FRAC_BITS;
  localparam int T_BITS        = TLOG_W + 1 - RND_SHIFT;
  localparam int PCALC_W       = (T_BITS > PWR_W) ? T_BITS : PWR_W;
  localparam int POWER_TOP     = 67 << POWER_FRAC_BITS;
  localparam int POWER_FLOOR   = 10 << POWER_FRAC_BITS;

  localparam logic [TENLOG2_W-1:0] TENLOG2_Q16 = TENLOG2_W'(197283);
  localparam logic [TLOG_W:0]      RND_ADD     = (TLOG_W + 1)'(1) << (RND_SHIFT - 1);
  localparam logic [PWR_W-1:0]     PWR_MAX     = '1;

  // pipeline stage positions
  localparam int ST_IN   = 0;
  localparam int ST_DIST = 1;
  localparam int ST_NORM = 2;
  localparam int ST_SQ0  = 3;
  localparam int ST_MUL  = ST_SQ0 + LOG_FRAC_BITS;
  localparam int ST_PWR  = ST_MUL + 1;
  localparam int ST_OUT  = ST_PWR + 1;
  localparam int NUM_ST  = ST_OUT + 1;
  localparam int LANE_ST = ST_PWR - ST_DIST + 1;

  localparam logic [11:0]     RST_THRESHOLD = 12'd240;
  localparam logic [11:0]     RST_MARGIN    = 12'd208;
  localparam logic [XY_W-1:0] RST_STN_A     = XY_W'(358730);
  localparam logic [XY_W-1:0] RST_STN_B     = XY_W'(318080);
  localparam logic [XY_W-1:0] RST_STN_C     = XY_W'(696680);
  localparam logic [XY_W-1:0] RST_STN_D     = XY_W'(674452);

  typedef enum logic [1:0] {
    POLICY_NEAREST,
    POLICY_LOW_POWER,
    POLICY_MARGIN,
    POLICY_COMBINED
  } policy_e;

  typedef enum logic [ADDR_W-3:0] {
    REG_POLICY,
    REG_THRESHOLD,
    REG_MARGIN,
    REG_STN_A,
    REG_STN_B,
    REG_STN_C,
    REG_STN_D
  } reg_idx_e;

  typedef struct packed {
    policy_e                            mode;
    logic [11:0]                        threshold;
    logic [11:0]                        margin;
    logic [NUM_STATIONS-1:0][XY_W-1:0]  station_xy;
  } cfg_t;

endpackage

/* design/chd_cfg.sv */
`timescale 1ns / 1ps

module chd_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [chd_pkg::ADDR_W-1:0]  paddr,
  input  logic [chd_pkg::DATA_W-1:0]  pwdata,
  output logic [chd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output chd_pkg::cfg_t               cfg_o
);
  import chd_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_POLICY:    cfg_d.mode          = policy_e'(pwdata[1:0]);
        REG_THRESHOLD: cfg_d.threshold     = pwdata[11:0];
        REG_MARGIN:    cfg_d.margin        = pwdata[11:0];
        REG_STN_A:     cfg_d.station_xy[0] = pwdata[XY_W-1:0];
        REG_STN_B:     cfg_d.station_xy[1] = pwdata[XY_W-1:0];
        REG_STN_C:     cfg_d.station_xy[2] = pwdata[XY_W-1:0];
        REG_STN_D:     cfg_d.station_xy[3] = pwdata[XY_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_POLICY:    prdata = DATA_W'(cfg_q.mode);
      REG_THRESHOLD: prdata = DATA_W'(cfg_q.threshold);
      REG_MARGIN:    prdata = DATA_W'(cfg_q.margin);
      REG_STN_A:     prdata = DATA_W'(cfg_q.station_xy[0]);
      REG_STN_B:     prdata = DATA_W'(cfg_q.station_xy[1]);
      REG_STN_C:     prdata = DATA_W'(cfg_q.station_xy[2]);
      REG_STN_D:     prdata = DATA_W'(cfg_q.station_xy[3]);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode          <= POLICY_NEAREST;
      cfg_q.threshold     <= RST_THRESHOLD;
      cfg_q.margin        <= RST_MARGIN;
      cfg_q.station_xy[0] <= RST_STN_A;
      cfg_q.station_xy[1] <= RST_STN_B;
      cfg_q.station_xy[2] <= RST_STN_C;
      cfg_q.station_xy[3] <= RST_STN_D;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/chd_lane.sv */
`timescale 1ns / 1ps

module chd_lane (
  input  logic                            clk_i,
  input  logic [chd_pkg::LANE_ST-1:0]     adv_i,
  input  logic [chd_pkg::COORD_BITS-1:0]  pos_x_i,
  input  logic [chd_pkg::COORD_BITS-1:0]  pos_y_i,
  input  logic [chd_pkg::XY_W-1:0]        stn_xy_i,
  output logic [chd_pkg::D2_W-1:0]        d2_o,
  output logic [chd_pkg::PWR_W-1:0]       power_o
);
  import chd_pkg::*;

  localparam int NS = LOG_FRAC_BITS;

  logic [COORD_BITS-1:0]     sx, sy, dx, dy;
  logic [2*COORD_BITS-1:0]   dx2, dy2;
  logic [D2_W-1:0]           d2_d, d2_q;
  logic [EXP_W-1:0]          e_d;
  logic [D2_W+MANT_W-2:0]    norm_w;
  logic [MANT_W-1:0]         m_d;

  logic [MANT_W-1:0]         m_q  [NS+1];
  logic [EXP_W-1:0]          e_q  [NS+1];
  logic [NS-1:0]             fr_q [NS+1];
  logic                      zr_q [NS+1];

  logic [2*MANT_W-1:0]       sq_w  [NS];
  logic [MANT_W:0]           sh_w  [NS];
  logic [MANT_W-1:0]         m_nx  [NS];
  logic [NS-1:0]             fr_nx [NS];

  logic [LOG_W-1:0]          log_w;
  logic [TLOG_W-1:0]         prod_d, prod_q;
  logic                      zr_mul_q;
  logic [TLOG_W:0]           rnd_w;
  logic [PCALC_W-1:0]        t_w, diff_w;
  logic [PWR_W-1:0]          pwr_d, pwr_q;

  // squared distance
  assign sx  = stn_xy_i[COORD_BITS-1:0];
  assign sy  = COORD_BITS'(stn_xy_i >> COORD_BITS);
  assign dx  = (pos_x_i > sx) ? pos_x_i - sx : sx - pos_x_i;
  assign dy  = (pos_y_i > sy) ? pos_y_i - sy : sy - pos_y_i;
  assign dx2 = (2*COORD_BITS)'(dx) * (2*COORD_BITS)'(dx);
  assign dy2 = (2*COORD_BITS)'(dy) * (2*COORD_BITS)'(dy);
  assign d2_d = {1'b0, dx2} + {1'b0, dy2};

  // exponent and q30 mantissa
  always_comb begin
    e_d = '0;
    for (int i = 0; i < D2_W; i++) begin
      if (d2_q[i]) begin
        e_d = EXP_W'(i);
      end
    end
    norm_w = {d2_q, (MANT_W-1)'(0)} >> e_d;
    m_d    = norm_w[MANT_W-1:0];
  end

  // one fraction bit of log2 per squaring stage
  always_comb begin
    for (int j = 0; j < NS; j++) begin
      sq_w[j]  = (2*MANT_W)'(m_q[j]) * (2*MANT_W)'(m_q[j]);
      sh_w[j]  = sq_w[j][2*MANT_W-1:MANT_W-1];
      m_nx[j]  = sh_w[j][MANT_W] ? sh_w[j][MANT_W:1] : sh_w[j][MANT_W-1:0];
      fr_nx[j] = fr_q[j] | (sh_w[j][MANT_W] ? (NS'(1) << (NS - 1 - j)) : NS'(0));
    end
  end

  assign log_w  = {e_q[NS], fr_q[NS]};
  assign prod_d = TLOG_W'(log_w) * TLOG_W'(TENLOG2_Q16);

  // round, subtract from 67 dB, clamp
  always_comb begin
    rnd_w  = {1'b0, prod_q} + RND_ADD;
    t_w    = PCALC_W'(rnd_w >> RND_SHIFT);
    diff_w = PCALC_W'(POWER_TOP) - t_w;
    if (zr_mul_q) begin
      pwr_d = PWR_MAX;
    end else if (t_w > PCALC_W'(POWER_TOP)) begin
      pwr_d = '0;
    end else if (diff_w < PCALC_W'(POWER_FLOOR)) begin
      pwr_d = '0;
    end else if (diff_w > PCALC_W'(PWR_MAX)) begin
      pwr_d = PWR_MAX;
    end else begin
      pwr_d = PWR_W'(diff_w);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[ST_DIST-ST_DIST]) begin
      d2_q <= d2_d;
    end
    if (adv_i[ST_NORM-ST_DIST]) begin
      m_q[0]  <= m_d;
      e_q[0]  <= e_d;
      fr_q[0] <= '0;
      zr_q[0] <= (d2_q == '0);
    end
    for (int j = 0; j < NS; j++) begin
      if (adv_i[ST_SQ0+j-ST_DIST]) begin
        m_q[j+1]  <= m_nx[j];
        e_q[j+1]  <= e_q[j];
        fr_q[j+1] <= fr_nx[j];
        zr_q[j+1] <= zr_q[j];
      end
    end
    if (adv_i[ST_MUL-ST_DIST]) begin
      prod_q   <= prod_d;
      zr_mul_q <= zr_q[NS];
    end
    if (adv_i[ST_PWR-ST_DIST]) begin
      pwr_q <= pwr_d;
    end
  end

  assign d2_o    = d2_q;
  assign power_o = pwr_q;

endmodule

/* design/chd_decide.sv */
`timescale 1ns / 1ps

module chd_decide (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          load_i,
  input  logic [chd_pkg::NUM_STATIONS-1:0][chd_pkg::PWR_W-1:0] power_i,
  input  logic [chd_pkg::STN_W-1:0]                     near_i,
  input  logic                                          force_i,
  input  chd_pkg::cfg_t                                 cfg_i,
  output logic [chd_pkg::SERV_W-1:0]                    station_o,
  output logic                                          handoff_o,
  output logic [chd_pkg::PWR_W-1:0]                     power_o
);
  import chd_pkg::*;

  logic [SERV_W-1:0] cur_q, cur_d, nx_stn;
  logic              cur_ok, low, gain, go, ho_d, ho_q;
  logic [PWR_W-1:0]  ps, pn, pwr_d, pwr_q;
  logic [PWR_W:0]    ps_m;

  always_comb begin
    nx_stn = SERV_W'(near_i) + SERV_W'(1);
    cur_ok = (cur_q >= SERV_W'(1)) && (cur_q <= SERV_W'(NUM_STATIONS));
    ps     = power_i[STN_W'(cur_q - SERV_W'(1))];
    pn     = power_i[near_i];
    ps_m   = {1'b0, ps} + {1'b0, cfg_i.margin};
    low    = ps < cfg_i.threshold;
    gain   = {1'b0, pn} > ps_m;
    case (cfg_i.mode)
      POLICY_NEAREST:   go = 1'b1;
      POLICY_LOW_POWER: go = low;
      POLICY_MARGIN:    go = gain;
      default:          go = low && gain;
    endcase
    cur_d = cur_q;
    ho_d  = 1'b0;
    if (!cur_ok || force_i) begin
      cur_d = nx_stn;
    end else if ((cur_q != nx_stn) && go) begin
      cur_d = nx_stn;
      ho_d  = 1'b1;
    end
    pwr_d = power_i[STN_W'(cur_d - SERV_W'(1))];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else if (load_i) begin
      cur_q <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ho_q  <= ho_d;
      pwr_q <= pwr_d;
    end
  end

  assign station_o = cur_q;
  assign handoff_o = ho_q;
  assign power_o   = pwr_q;

endmodule

/* design/cell_handoff_decision_core.sv */
`timescale 1ns / 1ps
`include "cell_handoff_decision_core_defines.svh"

// Handoff decision over four base stations. One position report can be taken every cycle and
// one decision comes out per cycle in steady state while the output is not stalled. Each
// accepted report passes the input register, then the power pipeline: one stage of
// squared distance, one of normalization, sixteen squaring stages (one 31x31 multiplier per
// stage in each of the four station lanes) that build the log2 fraction, one stage for the
// 10*log10(2) scaling and one for rounding and clamping, then the decision stage, which holds
// the serving station and drives the output ports. Empty stages collapse when the output is
// stalled, so input keeps being taken until every stage is full. Configuration goes through
// the register port; write it only while no report is in flight.
module cell_handoff_decision_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [chd_pkg::ADDR_W-1:0]        paddr,
  input  logic [chd_pkg::DATA_W-1:0]        pwdata,
  output logic [chd_pkg::DATA_W-1:0]        prdata,
  output logic                              pready,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pos_x [9:0], pos_y [19:10], zero [23:20]
  input  logic [chd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // force_nearest [0]
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // serving_station [2:0], serving_power [14:3], zero [15]
  output logic [chd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // handoff [0]
  output logic                              m_axis_tuser
);
  import chd_pkg::*;

  cfg_t                                 cfg;
  logic [NUM_ST-1:0]                    valid_q, valid_d, up_v, stg_rdy, adv;
  logic [COORD_BITS-1:0]                px_q, py_q;
  logic                                 frc_q  [ST_IN:ST_PWR];
  logic [STN_W-1:0]                     near_q [ST_NORM:ST_PWR];
  logic [NUM_STATIONS-1:0][D2_W-1:0]    d2;
  logic [NUM_STATIONS-1:0][PWR_W-1:0]   power;
  logic [D2_W-1:0]                      best;
  logic [STN_W-1:0]                     near_d;
  logic [SERV_W-1:0]                    serv_stn;
  logic [PWR_W-1:0]                     serv_pwr;
  logic                                 serv_ho;

  chd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // stage control: a stage may load when the output is ready or it or any stage after it is empty
  assign up_v[0] = s_axis_tvalid;
  for (genvar i = 0; i < NUM_ST; i++) begin : g_ctl
    if (i > 0) begin : g_up
      assign up_v[i] = valid_q[i-1];
    end
    assign stg_rdy[i] = m_axis_tready || !(&valid_q[NUM_ST-1:i]);
    assign adv[i]     = up_v[i] && stg_rdy[i];
    assign valid_d[i] = stg_rdy[i] ? up_v[i] : valid_q[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign s_axis_tready = stg_rdy[ST_IN];

  // input register and sideband that travels with each transaction
  always_ff @(posedge clk_i) begin
    if (adv[ST_IN]) begin
      px_q         <= COORD_BITS'(s_axis_tdata[POS_W-1:0]);
      py_q         <= COORD_BITS'(s_axis_tdata[2*POS_W-1:POS_W]);
      frc_q[ST_IN] <= s_axis_tuser;
    end
    for (int s = ST_DIST; s <= ST_PWR; s++) begin
      if (adv[s]) begin
        frc_q[s] <= frc_q[s-1];
      end
    end
    if (adv[ST_NORM]) begin
      near_q[ST_NORM] <= near_d;
    end
    for (int s = ST_NORM + 1; s <= ST_PWR; s++) begin
      if (adv[s]) begin
        near_q[s] <= near_q[s-1];
      end
    end
  end

  for (genvar k = 0; k < NUM_STATIONS; k++) begin : g_lane
    chd_lane u_lane (
      .clk_i    (clk_i),
      .adv_i    (adv[ST_PWR:ST_DIST]),
      .pos_x_i  (px_q),
      .pos_y_i  (py_q),
      .stn_xy_i (cfg.station_xy[k]),
      .d2_o     (d2[k]),
      .power_o  (power[k])
    );
  end

  // nearest station, lower index wins a tie
  always_comb begin
    best   = d2[0];
    near_d = '0;
    for (int k = 1; k < NUM_STATIONS; k++) begin
      if (d2[k] < best) begin
        best   = d2[k];
        near_d = STN_W'(k);
      end
    end
  end

  chd_decide u_decide (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (adv[ST_OUT]),
    .power_i   (power),
    .near_i    (near_q[ST_PWR]),
    .force_i   (frc_q[ST_PWR]),
    .cfg_i     (cfg),
    .station_o (serv_stn),
    .handoff_o (serv_ho),
    .power_o   (serv_pwr)
  );

  assign m_axis_tvalid = valid_q[ST_OUT];
  assign m_axis_tdata  = {(OUT_DATA_W - PWR_W - SERV_W)'(0), serv_pwr, serv_stn};
  assign m_axis_tuser  = serv_ho;

  `CHD_ASSERT_SAME(a_out_station_range, m_axis_tvalid,
                   (m_axis_tdata[2:0] != 3'd0) && (m_axis_tdata[2:0] <= 3'd4),
                   "serving station out of range")
  `CHD_ASSERT_SAME(a_full_blocks_input, (&valid_q) && !m_axis_tready, !s_axis_tready,
                   "input taken while every stage is full")
  `CHD_ASSERT_NEXT(a_out_load_valid, adv[ST_OUT], m_axis_tvalid,
                   "decision loaded without output valid")
  `CHD_ASSERT_NEXT(a_in_load_valid, s_axis_tvalid && s_axis_tready, valid_q[ST_IN],
                   "accepted transaction lost at input stage")

endmodule
